// ===== src/iurc_pkg.sv =====
// Shared types, constants and helpers for the IPv4/UDP receive checker.
`default_nettype none

package iurc_pkg;

   typedef enum logic [1:0] {
      LINK_LOOPBACK = 2'd0,
      LINK_ETHERNET = 2'd1,
      LINK_SLIP     = 2'd2,
      LINK_PPP      = 2'd3
   } link_type_type;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_NOT_IP      = 3'd1,
      STATUS_TOO_SHORT   = 3'd2,
      STATUS_BAD_VERSION = 3'd3,
      STATUS_BAD_HDR_LEN = 3'd4,
      STATUS_SHORT_UDP   = 3'd5,
      STATUS_BAD_CSUM    = 3'd6,
      STATUS_NOT_UDP     = 3'd7
   } status_type;

   typedef struct packed {
      status_type  status;
      logic        not_udp;
      logic [5:0]  header_bytes;
      logic [15:0] udp_checksum;
   } result_type;

   localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
   localparam logic [7:0]  PROTO_UDP        = 8'd17;
   localparam logic [3:0]  IP_VERSION_4     = 4'd4;
   localparam logic [5:0]  IP_MIN_HDR_BYTES = 6'd20;
   localparam logic [5:0]  UDP_HDR_BYTES    = 6'd8;
   localparam logic [15:0] ETHERTYPE_HI_IDX = 16'd12;
   localparam logic [15:0] ETHERTYPE_LO_IDX = 16'd13;
   localparam logic [15:0] IP_PROTO_REL     = 16'd9;
   localparam logic [15:0] UDP_CSUM_REL     = 16'd6;
   localparam logic [15:0] COUNT_MAX        = 16'hffff;

   function automatic logic [4:0] link_offset(input link_type_type kind);
      logic [4:0] offset;
      unique case (kind)
         LINK_LOOPBACK: offset = 5'd4;
         LINK_ETHERNET: offset = 5'd14;
         LINK_SLIP:     offset = 5'd24;
         LINK_PPP:      offset = 5'd24;
         default:       offset = 5'd24;
      endcase
      return offset;
   endfunction

endpackage

`default_nettype wire

// ===== src/iurc_if.sv =====
// Valid/ready channel interfaces for frame bytes, results and the link type register.
`default_nettype none

interface iurc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;
   modport source (output valid, output frame_byte, output last_byte, input ready);
   modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface iurc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        not_udp;
   logic [5:0]  header_bytes;
   logic [15:0] udp_checksum;
   modport source (output valid, output status, output not_udp, output header_bytes,
                   output udp_checksum, input ready);
   modport sink (input valid, input status, input not_udp, input header_bytes,
                 input udp_checksum, output ready);
endinterface

interface iurc_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] link_type;
   modport source (output valid, output link_type, input ready);
   modport sink (input valid, input link_type, output ready);
endinterface

`default_nettype wire

// ===== src/iurc_frame_track.sv =====
// Per-frame header tracking: byte counter, header checksum and field capture.
`default_nettype none

module iurc_frame_track
   import iurc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step_en,
   input  wire logic [7:0]    data_byte,
   input  wire logic          last_flag,
   input  wire link_type_type link_type,
   output result_type         result
);

   logic [15:0] byte_count_ff, byte_count_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  hold_ff, hold_in;
   logic [15:0] ether_ff, ether_in;
   logic [7:0]  vihl_ff, vihl_in;
   logic [7:0]  proto_ff, proto_in;
   logic [15:0] udp_ff, udp_in;

   logic [4:0]  offset;
   logic [15:0] offset_ext;
   logic        in_ip;
   logic [15:0] rel;
   logic [5:0]  hdr_len;
   logic [15:0] hdr_len_ext;
   logic [16:0] sum_wide;
   logic [15:0] frame_len;
   logic [15:0] udp_need;
   status_type  status;

   always_comb begin
      offset      = link_offset(link_type);
      offset_ext  = {11'd0, offset};
      in_ip       = (byte_count_ff >= offset_ext);
      rel         = byte_count_ff - offset_ext;

      ether_in = ether_ff;
      if (byte_count_ff == ETHERTYPE_HI_IDX) begin
         ether_in = {data_byte, ether_ff[7:0]};
      end else if (byte_count_ff == ETHERTYPE_LO_IDX) begin
         ether_in = {ether_ff[15:8], data_byte};
      end

      vihl_in = (in_ip && rel == 16'd0) ? data_byte : vihl_ff;
      hdr_len     = {vihl_in[3:0], 2'b00};
      hdr_len_ext = {10'd0, hdr_len};
      proto_in = (in_ip && rel == IP_PROTO_REL) ? data_byte : proto_ff;

      // Header words are summed with the end-around carry folded back in.
      hold_in  = hold_ff;
      sum_in   = sum_ff;
      sum_wide = {1'b0, sum_ff} + {1'b0, hold_ff, data_byte};
      if (in_ip && rel < hdr_len_ext) begin
         if (!rel[0]) begin
            hold_in = data_byte;
         end else begin
            sum_in = sum_wide[16] ? (sum_wide[15:0] + 16'd1) : sum_wide[15:0];
         end
      end

      udp_in = udp_ff;
      if (in_ip && rel == hdr_len_ext + UDP_CSUM_REL) begin
         udp_in = {data_byte, udp_ff[7:0]};
      end else if (in_ip && rel == hdr_len_ext + UDP_CSUM_REL + 16'd1) begin
         udp_in = {udp_ff[15:8], data_byte};
      end

      byte_count_in = (byte_count_ff == COUNT_MAX) ? byte_count_ff : byte_count_ff + 16'd1;

      frame_len = (byte_count_ff == COUNT_MAX) ? COUNT_MAX : byte_count_ff + 16'd1;
      udp_need  = {10'd0, hdr_len} + {10'd0, UDP_HDR_BYTES};

      priority if (link_type == LINK_ETHERNET && ether_in != ETHERTYPE_IPV4) begin
         status = STATUS_NOT_IP;
      end else if (frame_len < offset_ext + {10'd0, IP_MIN_HDR_BYTES}
                   + {10'd0, UDP_HDR_BYTES}) begin
         status = STATUS_TOO_SHORT;
      end else if (vihl_in[7:4] != IP_VERSION_4) begin
         status = STATUS_BAD_VERSION;
      end else if (hdr_len < IP_MIN_HDR_BYTES) begin
         status = STATUS_BAD_HDR_LEN;
      end else if (frame_len - offset_ext < udp_need) begin
         status = STATUS_SHORT_UDP;
      end else if (sum_in != 16'hffff) begin
         status = STATUS_BAD_CSUM;
      end else if (proto_in != PROTO_UDP) begin
         status = STATUS_NOT_UDP;
      end else begin
         status = STATUS_OK;
      end

      result.status       = status;
      result.not_udp      = (status == STATUS_NOT_UDP);
      result.header_bytes = hdr_len;
      result.udp_checksum = (status == STATUS_OK) ? udp_in : 16'd0;
   end

   // The last word of a frame clears everything for the next one.
   always_ff @(posedge clock) begin
      if (reset || (step_en && last_flag)) begin
         byte_count_ff <= '0;
         sum_ff        <= '0;
         hold_ff       <= '0;
         ether_ff      <= '0;
         vihl_ff       <= '0;
         proto_ff      <= '0;
         udp_ff        <= '0;
      end else if (step_en) begin
         byte_count_ff <= byte_count_in;
         sum_ff        <= sum_in;
         hold_ff       <= hold_in;
         ether_ff      <= ether_in;
         vihl_ff       <= vihl_in;
         proto_ff      <= proto_in;
         udp_ff        <= udp_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/ipv4_udp_receive_checker.sv =====
// IPv4/UDP receive checker: skips the link header, checks the IPv4 header and reports a status.
//
// Frame bytes arrive on req_if, one per word, in wire order; last_byte marks
// the final captured byte. Every byte is accepted into an input register; non-final bytes are
// processed in the following cycle; one word per clock is sustained unless a final byte stalls.
// Only the last byte of a frame yields a word on rsp_if: the status, the IP
// header length in bytes and the UDP checksum field (zero unless status is OK).
// That result word is loaded into the output register when the last byte is processed.
// The result sits in an output register; while it waits for rsp_if.ready the
// block keeps taking non-final bytes, and only stalls a final byte that would
// need the busy output register.
// csr_if writes the 2-bit link type (loopback, Ethernet, SLIP, PPP) and is
// always ready; change it only between frames.
// Reset empties both registers, clears the frame state and sets the link type
// to Ethernet.
`default_nettype none

module ipv4_udp_receive_checker
   import iurc_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   iurc_req_if.sink   req_if,
   iurc_rsp_if.source rsp_if,
   iurc_csr_if.sink   csr_if
);

   link_type_type link_type_ff;
   logic          in_valid_ff;
   logic [7:0]    in_byte_ff;
   logic          in_last_ff;
   logic          out_valid_ff, out_valid_in;
   result_type    out_result_ff;
   result_type    step_result;
   logic          step_go;

   assign step_go = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || step_go;
   assign csr_if.ready = 1'b1;

   iurc_frame_track u_track (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_go),
      .data_byte (in_byte_ff),
      .last_flag (in_last_ff),
      .link_type (link_type_ff),
      .result    (step_result)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (step_go && in_last_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_type_ff <= LINK_ETHERNET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_if.valid) begin
            link_type_ff <= link_type_type'(csr_if.link_type);
         end
         if (req_if.ready) begin
            in_valid_ff <= req_if.valid;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.frame_byte;
         in_last_ff <= req_if.last_byte;
      end
      if (step_go && in_last_ff) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.status       = out_result_ff.status;
   assign rsp_if.not_udp      = out_result_ff.not_udp;
   assign rsp_if.header_bytes = out_result_ff.header_bytes;
   assign rsp_if.udp_checksum = out_result_ff.udp_checksum;

endmodule

`default_nettype wire

// ===== src/iurc_checker.sv =====
// Port-level assertions for the IPv4/UDP receive checker, bound to the top level.
`default_nettype none

module iurc_checker
   import iurc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic        rsp_not_udp,
   input wire logic [5:0]  rsp_header_bytes,
   input wire logic [15:0] rsp_udp_checksum
);

   // A result never appears in the cycle right after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result word shown right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_not_udp == (rsp_status == STATUS_NOT_UDP)))
      else $error("not_udp disagrees with status");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_udp_checksum == 16'd0))
      else $error("UDP checksum reported on a failed header");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_header_bytes[1:0] == 2'b00))
      else $error("header length is not a multiple of four");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
                                     && $stable(rsp_udp_checksum)))
      else $error("stalled result word changed");

endmodule

bind ipv4_udp_receive_checker iurc_checker u_iurc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_status       (rsp_if.status),
   .rsp_not_udp      (rsp_if.not_udp),
   .rsp_header_bytes (rsp_if.header_bytes),
   .rsp_udp_checksum (rsp_if.udp_checksum)
);

`default_nettype wire

// ===== dv/iurc_frame_checker.sv =====
// Checker that predicts the IPv4/UDP receive checker's result words and compares them.
`default_nettype none

module iurc_frame_checker
   import iurc_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   iurc_req_if         req_if,
   iurc_rsp_if         rsp_if,
   iurc_csr_if         csr_if,
   output int unsigned error_count,
   output int unsigned results_pending,
   output int unsigned results_checked,
   output logic [7:0]  status_mask
);

   localparam int unsigned PRINT_LIMIT = 200;

   link_type_type link_kind;
   logic [15:0]   byte_index;
   logic [16:0]   header_sum;
   logic [7:0]    word_high;
   logic [15:0]   ethertype_seen;
   logic [7:0]    ver_ihl;
   logic [7:0]    protocol;
   logic [15:0]   udp_field;

   result_type  verdict_q[$];
   int unsigned errors = 0;
   int unsigned checked = 0;
   logic [7:0]  seen = '0;

   function automatic void clear_frame_state();
      byte_index = '0;
      header_sum = '0;
      word_high = '0;
      ethertype_seen = '0;
      ver_ihl = '0;
      protocol = '0;
      udp_field = '0;
   endfunction

   // Folds one frame byte into the running frame state; returns 1 with the
   // verdict filled in when the byte closes the frame.
   function automatic bit absorb_byte(input logic [7:0] octet, input logic last,
                                      output result_type verdict);
      int unsigned offset, rel, hdr_len, frame_len;
      status_type  code;
      verdict = '0;
      case (link_kind)
         LINK_LOOPBACK: offset = 4;
         LINK_ETHERNET: offset = 14;
         default:       offset = 24;
      endcase
      if (byte_index == 16'd12) begin
         ethertype_seen[15:8] = octet;
      end else if (byte_index == 16'd13) begin
         ethertype_seen[7:0] = octet;
      end
      if (byte_index >= offset) begin
         rel = byte_index - offset;
         if (rel == 0) begin
            ver_ihl = octet;
         end
         hdr_len = ver_ihl[3:0] * 4;
         if (rel == 9) begin
            protocol = octet;
         end
         if (rel < hdr_len) begin
            if (rel % 2 == 0) begin
               word_high = octet;
            end else begin
               // Ones-complement add: a carry out of bit 15 wraps back in.
               header_sum = header_sum + {1'b0, word_high, octet};
               if (header_sum[16]) begin
                  header_sum = {1'b0, header_sum[15:0]} + 17'd1;
               end
            end
         end
         if (rel == hdr_len + 6) begin
            udp_field[15:8] = octet;
         end else if (rel == hdr_len + 7) begin
            udp_field[7:0] = octet;
         end
      end
      if (!last) begin
         if (byte_index != 16'hffff) begin
            byte_index = byte_index + 16'd1;
         end
         return 1'b0;
      end
      frame_len = byte_index + 1;
      if (frame_len > 65535) begin
         frame_len = 65535;
      end
      hdr_len = ver_ihl[3:0] * 4;
      if (link_kind == LINK_ETHERNET && ethertype_seen != ETHERTYPE_IPV4) begin
         code = STATUS_NOT_IP;
      end else if (frame_len < offset + IP_MIN_HDR_BYTES + UDP_HDR_BYTES) begin
         code = STATUS_TOO_SHORT;
      end else if (ver_ihl[7:4] != IP_VERSION_4) begin
         code = STATUS_BAD_VERSION;
      end else if (hdr_len < IP_MIN_HDR_BYTES) begin
         code = STATUS_BAD_HDR_LEN;
      end else if (frame_len - offset < hdr_len + UDP_HDR_BYTES) begin
         code = STATUS_SHORT_UDP;
      end else if (header_sum[15:0] != 16'hffff) begin
         code = STATUS_BAD_CSUM;
      end else if (protocol != PROTO_UDP) begin
         code = STATUS_NOT_UDP;
      end else begin
         code = STATUS_OK;
      end
      verdict.status = code;
      verdict.not_udp = (code == STATUS_NOT_UDP);
      verdict.header_bytes = 6'(hdr_len);
      verdict.udp_checksum = (code == STATUS_OK) ? udp_field : 16'd0;
      clear_frame_state();
      return 1'b1;
   endfunction

   function automatic void compare_field(input string field, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= PRINT_LIMIT) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
         end
      end
   endfunction

   always @(posedge clock) begin : watch
      result_type verdict, want;
      if (reset) begin
         link_kind = LINK_ETHERNET;
         clear_frame_state();
         verdict_q.delete();
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            link_kind = link_type_type'(csr_if.link_type);
         end
         // Results are compared before this edge's byte is folded in, since a
         // result word never belongs to a byte accepted at the same edge.
         if (rsp_if.valid && rsp_if.ready) begin
            if (verdict_q.size() == 0) begin
               errors++;
               if (errors <= PRINT_LIMIT) begin
                  $display("%0t: expected no result word, got status %0h header_bytes %0h %s %0h",
                           $time, rsp_if.status, rsp_if.header_bytes, "udp_checksum",
                           rsp_if.udp_checksum);
               end
            end else begin
               want = verdict_q.pop_front();
               checked++;
               seen[want.status] = 1'b1;
               compare_field("status", 16'(want.status), 16'(rsp_if.status));
               compare_field("not_udp", 16'(want.not_udp), 16'(rsp_if.not_udp));
               compare_field("header_bytes", 16'(want.header_bytes), 16'(rsp_if.header_bytes));
               compare_field("udp_checksum", want.udp_checksum, rsp_if.udp_checksum);
            end
         end
         if (req_if.valid && req_if.ready) begin
            if (absorb_byte(req_if.frame_byte, req_if.last_byte, verdict)) begin
               verdict_q.push_back(verdict);
            end
         end
      end
      error_count <= errors;
      results_pending <= verdict_q.size();
      results_checked <= checked;
      status_mask <= seen;
   end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Top of the testbench: clock, reset, frame stimulus, receiver stalls and the verdict.
`default_nettype none

module testbench;
   import iurc_pkg::*;

   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int unsigned WATCHDOG_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset;

   iurc_req_if req_if ();
   iurc_rsp_if rsp_if ();
   iurc_csr_if csr_if ();

   int unsigned   error_count, results_pending, results_checked;
   logic [7:0]    status_mask;
   int unsigned   rsp_stall_pct;
   logic          hold_go;
   int unsigned   hold_left;
   int unsigned   quiet_cycles;
   int unsigned   req_idle_pct = 0;
   int unsigned   frames_sent = 0;
   int unsigned   bytes_sent = 0;
   link_type_type link_now = LINK_ETHERNET;
   logic [7:0]    frame_bytes[$];

   always #5 clock = ~clock;

   ipv4_udp_receive_checker u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   iurc_frame_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_if),
      .rsp_if          (rsp_if),
      .csr_if          (csr_if),
      .error_count     (error_count),
      .results_pending (results_pending),
      .results_checked (results_checked),
      .status_mask     (status_mask)
   );

   // Receiver: random stalls, or a long hold-off counted down here once requested.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         rsp_if.ready <= 1'b0;
      end else if (hold_go) begin
         hold_left <= HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no word moved on any channel for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Lays out link header, IPv4 header, UDP header and payload for the current
   // link type. A nonzero cut_len truncates the frame to that many bytes.
   function automatic void build_frame(input logic [15:0] ethertype, input logic [3:0] version,
                                       input logic [3:0] ihl, input logic [7:0] proto,
                                       input bit good_sum, input logic [15:0] udp_sum,
                                       input int unsigned payload, input int unsigned cut_len);
      int unsigned offset, hdr_len, ip_area, total, i;
      logic [16:0] acc;
      frame_bytes.delete();
      offset = link_offset(link_now);
      hdr_len = ihl * 4;
      ip_area = (hdr_len < 20) ? 20 : hdr_len;
      total = offset + ip_area + 8 + payload;
      for (i = 0; i < total; i++) begin
         frame_bytes.push_back(8'($urandom));
      end
      if (link_now == LINK_ETHERNET) begin
         frame_bytes[12] = ethertype[15:8];
         frame_bytes[13] = ethertype[7:0];
      end
      frame_bytes[offset] = {version, ihl};
      frame_bytes[offset + 9] = proto;
      frame_bytes[offset + hdr_len + 6] = udp_sum[15:8];
      frame_bytes[offset + hdr_len + 7] = udp_sum[7:0];
      if (good_sum && hdr_len >= 20) begin
         frame_bytes[offset + 10] = 8'h00;
         frame_bytes[offset + 11] = 8'h00;
         acc = '0;
         for (i = 0; i < hdr_len; i += 2) begin
            acc = acc + {1'b0, frame_bytes[offset + i], frame_bytes[offset + i + 1]};
            if (acc[16]) begin
               acc = {1'b0, acc[15:0]} + 17'd1;
            end
         end
         frame_bytes[offset + 10] = ~acc[15:8];
         frame_bytes[offset + 11] = ~acc[7:0];
      end
      if (cut_len != 0 && cut_len < total) begin
         frame_bytes = frame_bytes[0:cut_len - 1];
      end
   endfunction

   // Mostly well-formed frames with random content; the rest is noise and truncation.
   function automatic void random_frame();
      logic [3:0] ihl;
      if ($urandom_range(99) < 70) begin
         build_frame(ETHERTYPE_IPV4, IP_VERSION_4,
                     ($urandom_range(3) == 0) ? 4'($urandom_range(15, 6)) : 4'd5,
                     ($urandom_range(9) == 0) ? 8'($urandom) : PROTO_UDP,
                     $urandom_range(9) != 0,
                     ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom),
                     $urandom_range(12), 0);
      end else begin
         ihl = 4'($urandom);
         build_frame(($urandom_range(1) == 1) ? ETHERTYPE_IPV4 : 16'($urandom),
                     ($urandom_range(1) == 1) ? IP_VERSION_4 : 4'($urandom),
                     ihl, 8'($urandom), $urandom_range(1) == 1, 16'($urandom),
                     $urandom_range(12),
                     $urandom_range(link_offset(link_now) + ihl * 4 + 10, 1));
      end
   endfunction

   task automatic send_frame();
      int unsigned i;
      for (i = 0; i < frame_bytes.size(); i++) begin
         while ($urandom_range(99) < req_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
         req_if.valid <= 1'b1;
         req_if.frame_byte <= frame_bytes[i];
         req_if.last_byte <= (i + 1 == frame_bytes.size());
         do @(posedge clock); while (!req_if.ready);
      end
      frames_sent++;
      bytes_sent += frame_bytes.size();
   endtask

   // Stops offering bytes and waits until every predicted result word is back.
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_link(input link_type_type kind);
      csr_if.valid <= 1'b1;
      csr_if.link_type <= kind;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      link_now = kind;
   endtask

   initial begin : stimulus
      link_type_type phase_links [4] = '{LINK_LOOPBACK, LINK_PPP, LINK_ETHERNET, LINK_SLIP};
      int unsigned phase, phase_frames, phase_bytes, i;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.frame_byte <= 8'h00;
      req_if.last_byte <= 1'b0;
      csr_if.valid <= 1'b0;
      csr_if.link_type <= LINK_ETHERNET;
      rsp_stall_pct <= 0;
      hold_go <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed frames on the reset link type (Ethernet), covering every status code.
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 1, 16'hbeef, 4, 0);
      send_frame();
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 1, 16'h0000, 0, 0);
      send_frame();
      build_frame(16'h86dd, IP_VERSION_4, 4'd5, PROTO_UDP, 1, 16'h1234, 2, 0);
      send_frame();
      // Truncated frames: a single byte, one cut inside the link header, one a byte short.
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 1, 16'h1234, 0, 1);
      send_frame();
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 1, 16'h1234, 0, 13);
      send_frame();
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 1, 16'h1234, 0, 41);
      send_frame();
      build_frame(ETHERTYPE_IPV4, 4'd6, 4'd5, PROTO_UDP, 1, 16'h1234, 0, 0);
      send_frame();
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd4, PROTO_UDP, 1, 16'h1234, 0, 0);
      send_frame();
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd15, PROTO_UDP, 1, 16'hffff, 0, 81);
      send_frame();
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd15, PROTO_UDP, 1, 16'hffff, 3, 0);
      send_frame();
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 0, 16'h1234, 0, 0);
      send_frame();
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, 8'd6, 1, 16'h1234, 0, 0);
      send_frame();

      settle();
      write_link(LINK_LOOPBACK);
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 1, 16'h5a5a, 1, 0);
      send_frame();
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 1, 16'h5a5a, 0, 31);
      send_frame();
      settle();
      write_link(LINK_PPP);
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd7, PROTO_UDP, 1, 16'ha5a5, 2, 0);
      send_frame();
      settle();
      write_link(LINK_SLIP);
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 1, 16'h0f0f, 0, 0);
      send_frame();

      // Random frames, with the link type and the gap/stall mix changing per phase.
      for (phase = 0; phase < 4; phase++) begin
         settle();
         write_link(phase_links[phase]);
         case (phase)
            0: begin
               req_idle_pct = 0;
               rsp_stall_pct <= 0;
            end
            1: begin
               req_idle_pct = 73;
               rsp_stall_pct <= 0;
            end
            2: begin
               req_idle_pct = 0;
               rsp_stall_pct <= 73;
            end
            default: begin
               req_idle_pct = 20;
               rsp_stall_pct <= 20;
            end
         endcase
         phase_frames = 0;
         phase_bytes = 0;
         while (phase_frames < 1 || phase_bytes < 30) begin
            random_frame();
            phase_bytes += frame_bytes.size();
            phase_frames++;
            send_frame();
         end
      end

      // Receiver holds off while frames keep coming, so a final byte has to wait.
      settle();
      write_link(LINK_ETHERNET);
      req_idle_pct = 0;
      rsp_stall_pct <= 0;
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      for (i = 0; i < 3; i++) begin
         random_frame();
         send_frame();
      end

      settle();
      $display("Sent %0d frames (%0d bytes) over all four link types, with idle and stall mixes",
               frames_sent, bytes_sent);
      $display("and one long receiver hold-off; %0d result words checked, status codes hit %b.",
               results_checked, status_mask);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
